>>> src/resp_pkg.sv
// ----------------------------------------------------------------------------
// resp_pkg
// Shared types and constants of the stream parser: event and status codes,
// the classified operation that goes from the front end to the back end,
// and the queue geometry.
// ----------------------------------------------------------------------------
package resp_pkg;

  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int DEPTH_W = 4;

  // result beat packing
  localparam int TDATA_W = 80;
  localparam int TUSER_W = 5;

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_STR_END  = 3'd1,
    EV_ERR_END  = 3'd2,
    EV_INT      = 3'd3,
    EV_BULK_HDR = 3'd4,
    EV_BULK_END = 3'd5,
    EV_ARRAY    = 3'd6,
    EV_FAULT    = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TYPE   = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_LIMIT      = 2'd3
  } status_t;

  // One classified byte. A quiet op carries no event of its own and is
  // queued only to run the buffer-end check against the array stack.
  typedef struct packed {
    event_t               ev;
    logic                 quiet;
    logic                 last;
    logic [VALUE_W-1:0]   value;
    logic [BYTE_W-1:0]    pbyte;
    status_t              status;
  } op_t;

endpackage

>>> src/resp_front.sv
// ----------------------------------------------------------------------------
// resp_front
// Byte classifier: tracks the token phase, accumulates decimal headers,
// counts bulk payload; queues each byte's op unless quiet and not buffer end.
// ----------------------------------------------------------------------------
module resp_front #(
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [resp_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        push,
  output resp_pkg::op_t               op
);

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [63:0] CntMask = {64{1'b1}} >> (64 - COUNT_BITS);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LINE, PH_LINE_LF, PH_NUM, PH_NUM_LF,
    PH_BULK_DATA, PH_BULK_CR, PH_BULK_LF
  } phase_t;

  typedef enum logic [2:0] {K_STR, K_ERR, K_INT, K_BULK, K_ARR} kind_t;

  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [63:0] accum, accum_next;
  logic [63:0] bulk_rem, bulk_rem_next;
  logic [63:0] accum_x10;
  logic [63:0] digit;
  resp_pkg::status_t st;
  logic        accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign accum_x10 = {accum[60:0], 3'b000} + {accum[62:0], 1'b0};
  assign digit     = {56'd0, in_byte} - {56'd0, ChZero};

  always_comb begin
    phase_next    = phase;
    kind_next     = kind;
    accum_next    = accum;
    bulk_rem_next = bulk_rem;
    st            = resp_pkg::ST_OK;
    op.ev         = resp_pkg::EV_PAYLOAD;
    op.quiet      = 1'b1;
    op.last       = in_last;
    op.value      = '0;
    op.pbyte      = '0;
    op.status     = resp_pkg::ST_OK;

    unique case (phase)
      PH_IDLE: begin
        accum_next = '0;
        priority if (in_byte == ChPlus) begin
          kind_next = K_STR; phase_next = PH_LINE;
        end else if (in_byte == ChMinus) begin
          kind_next = K_ERR; phase_next = PH_LINE;
        end else if (in_byte == ChColon) begin
          kind_next = K_INT; phase_next = PH_NUM;
        end else if (in_byte == ChDollar) begin
          kind_next = K_BULK; phase_next = PH_NUM;
        end else if (in_byte == ChStar) begin
          kind_next = K_ARR; phase_next = PH_NUM;
        end else begin
          st = resp_pkg::ST_BAD_TYPE;
        end
      end
      PH_LINE: begin
        if (in_byte == ChCr) begin
          phase_next = PH_LINE_LF;
        end else begin
          op.quiet = 1'b0;
          op.ev    = resp_pkg::EV_PAYLOAD;
          op.pbyte = in_byte;
        end
      end
      PH_LINE_LF: begin
        // the byte after CR is taken as LF unchecked
        op.quiet   = 1'b0;
        op.ev      = (kind == K_ERR) ? resp_pkg::EV_ERR_END : resp_pkg::EV_STR_END;
        phase_next = PH_IDLE;
      end
      PH_NUM: begin
        if (in_byte == ChCr) begin
          phase_next = PH_NUM_LF;
        end else begin
          accum_next = accum_x10 + digit;
        end
      end
      PH_NUM_LF: begin
        phase_next = PH_IDLE;
        priority if (kind == K_BULK) begin
          op.quiet      = 1'b0;
          op.ev         = resp_pkg::EV_BULK_HDR;
          op.value      = accum;
          bulk_rem_next = accum;
          phase_next    = (accum != '0) ? PH_BULK_DATA : PH_BULK_CR;
        end else if (kind == K_ARR) begin
          if ((accum & ~CntMask) != '0) begin
            st = resp_pkg::ST_LIMIT;
          end else begin
            op.quiet = 1'b0;
            op.ev    = resp_pkg::EV_ARRAY;
            op.value = accum;
          end
        end else begin
          op.quiet = 1'b0;
          op.ev    = resp_pkg::EV_INT;
          op.value = accum;
        end
      end
      PH_BULK_DATA: begin
        op.quiet      = 1'b0;
        op.ev         = resp_pkg::EV_PAYLOAD;
        op.pbyte      = in_byte;
        bulk_rem_next = bulk_rem - 64'd1;
        if (bulk_rem == 64'd1) begin
          phase_next = PH_BULK_CR;
        end
      end
      PH_BULK_CR: begin
        if (in_byte != ChCr) st = resp_pkg::ST_INCOMPLETE;
        else phase_next = PH_BULK_LF;
      end
      PH_BULK_LF: begin
        if (in_byte != ChLf) begin
          st = resp_pkg::ST_INCOMPLETE;
        end else begin
          op.quiet   = 1'b0;
          op.ev      = resp_pkg::EV_BULK_END;
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    // buffer ends inside an open token
    if (st == resp_pkg::ST_OK && in_last && phase_next != PH_IDLE) begin
      st = resp_pkg::ST_INCOMPLETE;
    end

    if (st != resp_pkg::ST_OK) begin
      op.quiet   = 1'b0;
      op.ev      = resp_pkg::EV_FAULT;
      op.value   = '0;
      op.pbyte   = '0;
      op.status  = st;
      phase_next = PH_IDLE;
    end
  end

  // drop quiet bytes unless they end the buffer
  assign push = accept && (!op.quiet || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      kind     <= K_STR;
      accum    <= '0;
      bulk_rem <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      kind     <= kind_next;
      accum    <= accum_next;
      bulk_rem <= bulk_rem_next;
    end
  end

endmodule

>>> src/resp_queue.sv
// ----------------------------------------------------------------------------
// resp_queue
// Short register queue of classified ops between front and back end.
// ----------------------------------------------------------------------------
module resp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  resp_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output resp_pkg::op_t head_op
);

  resp_pkg::op_t                   slots [resp_pkg::QDEPTH];
  logic [resp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [resp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [resp_pkg::QCNT_W-1:0]     count;

  assign full       = (count == resp_pkg::QCNT_W'(resp_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + resp_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + resp_pkg::QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + resp_pkg::QCNT_W'(1);
        2'b01:   count <= count - resp_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/resp_back.sv
// ----------------------------------------------------------------------------
// resp_back
// Array stack and result stage: applies each op to the nesting stack,
// resolves element completion, depth faults and the buffer-end check, and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module resp_back #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  resp_pkg::op_t                head_op,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output resp_pkg::event_t             out_ev,
  output logic [resp_pkg::VALUE_W-1:0] out_value,
  output logic [resp_pkg::BYTE_W-1:0]  out_pbyte,
  output logic [resp_pkg::DEPTH_W-1:0] out_depth,
  output logic                         out_done,
  output resp_pkg::status_t            out_status
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [COUNT_BITS-1:0] pending [MAX_DEPTH];
  logic [LVL_W-1:0]      level, level_next;
  logic [IDX_W-1:0]      target;
  logic                  found;
  logic                  complete;
  logic                  push_en;
  logic                  dec_en;
  logic                  have;
  logic                  done;
  resp_pkg::status_t     st;

  assign pop = head_valid && (!out_valid || out_ready);

  // highest open level whose count does not run out with this element
  always_comb begin
    found  = 1'b0;
    target = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LVL_W'(i) < level && pending[i] != COUNT_BITS'(1)) begin
        found  = 1'b1;
        target = IDX_W'(i);
      end
    end
  end

  always_comb begin
    level_next = level;
    complete   = 1'b0;
    push_en    = 1'b0;
    dec_en     = 1'b0;
    done       = 1'b0;
    have       = 1'b0;
    st         = head_op.status;

    if (head_op.ev == resp_pkg::EV_FAULT) begin
      have = 1'b1;
    end else if (!head_op.quiet) begin
      have = 1'b1;
      unique case (head_op.ev)
        resp_pkg::EV_STR_END, resp_pkg::EV_ERR_END,
        resp_pkg::EV_INT, resp_pkg::EV_BULK_END: complete = 1'b1;
        resp_pkg::EV_ARRAY: begin
          priority if (head_op.value == '0) begin
            complete = 1'b1;
          end else if (level >= LVL_W'(MAX_DEPTH)) begin
            st = resp_pkg::ST_LIMIT;
          end else begin
            push_en    = 1'b1;
            level_next = level + LVL_W'(1);
          end
        end
        default: ;
      endcase
    end

    if (complete) begin
      if (found) begin
        dec_en     = 1'b1;
        level_next = LVL_W'(target) + LVL_W'(1);
      end else begin
        level_next = '0;
        done       = 1'b1;
      end
    end

    if (st == resp_pkg::ST_OK && head_op.last && level_next != '0) begin
      st = resp_pkg::ST_INCOMPLETE;
    end

    if (st != resp_pkg::ST_OK) begin
      have       = 1'b1;
      done       = 1'b0;
      level_next = '0;
    end
  end

  // each stack entry loads on push and counts down in place
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (pop && push_en && level == LVL_W'(i)) begin
        pending[i] <= head_op.value[COUNT_BITS-1:0];
      end else if (pop && dec_en && target == IDX_W'(i)) begin
        pending[i] <= pending[i] - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      level     <= level_next;
      out_valid <= have;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_depth <= resp_pkg::DEPTH_W'(level);
      if (st != resp_pkg::ST_OK) begin
        out_ev     <= resp_pkg::EV_FAULT;
        out_value  <= '0;
        out_pbyte  <= '0;
        out_done   <= 1'b0;
        out_status <= st;
      end else begin
        out_ev     <= head_op.ev;
        out_value  <= head_op.value;
        out_pbyte  <= head_op.pbyte;
        out_done   <= done;
        out_status <= resp_pkg::ST_OK;
      end
    end
  end

endmodule

>>> src/resp_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_stream_parser
// Byte-serial tokenizer for the RESP2 request format with bounded array
// nesting and a decoupled classifier / stack stage.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser / tlast
//  --------+-----+-----------------------------------------+------------------
//  s_*     | in  | [7:0] in_byte                           | tlast = in_last
//  m_*     | out | [63:0] value, [71:64] payload_byte,     | tuser [2:0] event,
//          |     | [75:72] depth, [79:76] zero             | [4:3] status;
//          |     |                                         | tlast = msg done
//
//  One byte per cycle sustained while the op queue has room. A result beat
//  passes through the classifier and op queue, then the stack stage and its
//  output register. Header bytes, digits and CRs outside bulk payload cause
//  no beat unless they fault. rst (synchronous) returns the parser to idle
//  with an empty array stack. When m_tready is low the result register holds,
//  the four-entry op queue fills, and s_tready drops once it is full.
//
module resp_stream_parser #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // input byte stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // [7:0] in_byte
  input  logic                         s_tlast,  // in_last
  // token stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [resp_pkg::TDATA_W-1:0] m_tdata,  // value, payload_byte, depth
  output logic [resp_pkg::TUSER_W-1:0] m_tuser,  // event_res, status
  output logic                         m_tlast   // message_done
);

  resp_pkg::op_t                    front_op;
  resp_pkg::op_t                    head_op;
  logic                             push;
  logic                             q_full;
  logic                             head_valid;
  logic                             pop;
  resp_pkg::event_t                 out_ev;
  resp_pkg::status_t                out_status;
  logic [resp_pkg::VALUE_W-1:0]     out_value;
  logic [resp_pkg::BYTE_W-1:0]      out_pbyte;
  logic [resp_pkg::DEPTH_W-1:0]     out_depth;

  // classify each accepted byte against the token phase
  resp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .op       (front_op)
  );

  // decouple the classifier from result backpressure
  resp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // advance the array stack and register the result beat
  resp_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ev     (out_ev),
    .out_value  (out_value),
    .out_pbyte  (out_pbyte),
    .out_depth  (out_depth),
    .out_done   (m_tlast),
    .out_status (out_status)
  );

  assign m_tdata = {4'b0000, out_depth, out_pbyte, out_value};
  assign m_tuser = {out_status, out_ev};

endmodule

>>> sim/resp_stream_parser_tb.sv
// ----------------------------------------------------------------------------
// resp_stream_parser_tb
// Self-checking bench for the byte-serial RESP2 tokenizer. A cycle-level
// token predictor runs on every accepted input beat. Each output beat is
// compared field by field with the oldest predicted token. Directed cases
// cover every token kind and the fault paths. A random phase then sends
// mostly well-formed nested messages with some corrupted or cut-short ones.
// Both sides idle at random, and the receiver stalls long enough once to
// fill the block.
// ----------------------------------------------------------------------------
module resp_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_LIMIT = 8;
  localparam int COUNT_W     = 32;

  typedef logic [7:0] byte_t;

  // protocol bytes
  localparam byte_t CH_STR  = 8'h2B;  // '+'
  localparam byte_t CH_ERR  = 8'h2D;  // '-'
  localparam byte_t CH_INT  = 8'h3A;  // ':'
  localparam byte_t CH_BULK = 8'h24;  // '$'
  localparam byte_t CH_ARR  = 8'h2A;  // '*'
  localparam byte_t CH_CR   = 8'h0D;
  localparam byte_t CH_LF   = 8'h0A;
  localparam byte_t CH_ZERO = 8'h30;  // '0'

  typedef enum logic [2:0] {
    PH_IDLE, PH_LINE, PH_LINE_LF, PH_NUM, PH_NUM_LF, PH_BULK_DATA, PH_BULK_CR, PH_BULK_LF
  } parse_phase_t;

  typedef enum logic [2:0] {TK_STR, TK_ERR, TK_INT, TK_BULK, TK_ARR} tok_kind_t;

  // one token as it appears on the output stream
  typedef struct packed {
    resp_pkg::event_t  ev;
    logic [63:0]       value;
    logic [7:0]        pbyte;
    logic [3:0]        depth;
    logic              done;
    resp_pkg::status_t status;
  } token_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = 8'h00;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [resp_pkg::TDATA_W-1:0]  m_tdata;
  logic [resp_pkg::TUSER_W-1:0]  m_tuser;
  logic                          m_tlast;

  // predictor state
  parse_phase_t ph;
  tok_kind_t    tok_kind;
  logic [63:0]  num_acc;
  logic [63:0]  bulk_left;
  logic [COUNT_W-1:0] elems_left [DEPTH_LIMIT];
  logic [3:0]   nest_lvl;

  token_t token_q [$];     // predicted tokens, oldest first
  byte_t  frame_q [$];     // bytes of the message batch being built
  int     err_count = 0;

  // idling controls
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;         // cycles of forced receiver hold-off
  int rx_wait = 0;

  resp_stream_parser #(
    .MAX_DEPTH  (DEPTH_LIMIT),
    .COUNT_BITS (COUNT_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: several times the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL resp_stream_parser");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------

  // Retire one element through the open arrays; an array whose count drops
  // to zero is itself an element of its parent. Return 1 on a whole message.
  function automatic logic close_element();
    while (nest_lvl != 0) begin
      elems_left[nest_lvl-1] = elems_left[nest_lvl-1] - 1'b1;
      if (elems_left[nest_lvl-1] != 0) return 1'b0;
      nest_lvl = nest_lvl - 1'b1;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one input byte; return 1 if a token comes out.
  function automatic bit predict_token(input byte_t b, input logic last, output token_t t);
    bit                have;
    resp_pkg::status_t st;
    logic [3:0]        dep;
    have = 1'b0;
    st   = resp_pkg::ST_OK;
    dep  = nest_lvl;
    t    = '0;
    case (ph)
      PH_IDLE: begin
        num_acc = '0;
        case (b)
          CH_STR:  begin tok_kind = TK_STR;  ph = PH_LINE; end
          CH_ERR:  begin tok_kind = TK_ERR;  ph = PH_LINE; end
          CH_INT:  begin tok_kind = TK_INT;  ph = PH_NUM;  end
          CH_BULK: begin tok_kind = TK_BULK; ph = PH_NUM;  end
          CH_ARR:  begin tok_kind = TK_ARR;  ph = PH_NUM;  end
          default: st = resp_pkg::ST_BAD_TYPE;
        endcase
      end
      PH_LINE: begin
        if (b == CH_CR) ph = PH_LINE_LF;
        else begin
          have    = 1'b1;
          t.ev    = resp_pkg::EV_PAYLOAD;
          t.pbyte = b;
        end
      end
      PH_LINE_LF: begin
        // byte after CR is taken as LF unchecked
        have   = 1'b1;
        t.ev   = (tok_kind == TK_ERR) ? resp_pkg::EV_ERR_END : resp_pkg::EV_STR_END;
        t.done = close_element();
        ph     = PH_IDLE;
      end
      PH_NUM: begin
        if (b == CH_CR) ph = PH_NUM_LF;
        else num_acc = num_acc * 64'd10 + 64'(b) - 64'(CH_ZERO);
      end
      PH_NUM_LF: begin
        ph = PH_IDLE;
        if (tok_kind == TK_BULK) begin
          have      = 1'b1;
          t.ev      = resp_pkg::EV_BULK_HDR;
          t.value   = num_acc;
          bulk_left = num_acc;
          ph        = (num_acc != 0) ? PH_BULK_DATA : PH_BULK_CR;
        end else if (tok_kind == TK_ARR) begin
          if ((num_acc >> COUNT_W) != 0) st = resp_pkg::ST_LIMIT;
          else if (num_acc == 0) begin
            have   = 1'b1;
            t.ev   = resp_pkg::EV_ARRAY;
            t.done = close_element();
          end else if (nest_lvl >= DEPTH_LIMIT) st = resp_pkg::ST_LIMIT;
          else begin
            elems_left[nest_lvl] = num_acc[COUNT_W-1:0];
            nest_lvl = nest_lvl + 1'b1;
            have     = 1'b1;
            t.ev     = resp_pkg::EV_ARRAY;
            t.value  = num_acc;
          end
        end else begin
          have    = 1'b1;
          t.ev    = resp_pkg::EV_INT;
          t.value = num_acc;
          t.done  = close_element();
        end
      end
      PH_BULK_DATA: begin
        have      = 1'b1;
        t.ev      = resp_pkg::EV_PAYLOAD;
        t.pbyte   = b;
        bulk_left = bulk_left - 1'b1;
        if (bulk_left == 0) ph = PH_BULK_CR;
      end
      PH_BULK_CR: begin
        if (b != CH_CR) st = resp_pkg::ST_INCOMPLETE;
        else ph = PH_BULK_LF;
      end
      PH_BULK_LF: begin
        if (b != CH_LF) st = resp_pkg::ST_INCOMPLETE;
        else begin
          have   = 1'b1;
          t.ev   = resp_pkg::EV_BULK_END;
          t.done = close_element();
          ph     = PH_IDLE;
        end
      end
      default: ph = PH_IDLE;
    endcase

    // buffer end with anything still open replaces this byte's token
    if (st == resp_pkg::ST_OK && last && (ph != PH_IDLE || nest_lvl != 0)) begin
      st = resp_pkg::ST_INCOMPLETE;
    end
    if (st != resp_pkg::ST_OK) begin
      have     = 1'b1;
      t        = '0;
      t.ev     = resp_pkg::EV_FAULT;
      t.status = st;
      ph       = PH_IDLE;
      nest_lvl = '0;
    end
    t.depth = dep;
    return have;
  endfunction

  function automatic string show_token(input token_t t);
    return $sformatf("ev=%0d value=%h byte=%h depth=%0d done=%b status=%0d",
                     t.ev, t.value, t.pbyte, t.depth, t.done, t.status);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every output beat.
  // Both sample pre-edge values, so ordering within the step does not matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    token_t want;
    token_t seen;
    if (rst) begin
      ph        = PH_IDLE;
      tok_kind  = TK_STR;
      num_acc   = '0;
      bulk_left = '0;
      nest_lvl  = '0;
      foreach (elems_left[i]) elems_left[i] = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (predict_token(s_tdata, s_tlast, want)) token_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        seen.value  = m_tdata[63:0];
        seen.pbyte  = m_tdata[71:64];
        seen.depth  = m_tdata[75:72];
        seen.ev     = resp_pkg::event_t'(m_tuser[2:0]);
        seen.status = resp_pkg::status_t'(m_tuser[4:3]);
        seen.done   = m_tlast;
        if (token_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected token: %s", show_token(seen));
        end else begin
          want = token_q.pop_front();
          if (seen !== want) begin
            err_count++;
            if (err_count <= 10) begin
              $display("token mismatch: expected %s", show_token(want));
              $display("                got      %s", show_token(seen));
            end
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draw a stall after each accepted beat; honor forced hold-offs.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
      rx_wait = 0;
    end else if (m_tvalid && m_tready) begin
      rx_wait = rx_idle ? $urandom_range(0, 18) : 0;
      m_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= (rx_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one beat, after a random gap when tx_idle is set, and return at the edge that takes it.
  // With no gap, valid stays high straight into the next beat.
  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Send text; '^' stands for CR and '~' for LF. Mark the final byte as
  // buffer end when asked.
  task automatic send_text(input string s, input logic end_last);
    byte_t c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == "^") c = CH_CR;
      else if (c == "~") c = CH_LF;
      send_byte(c, end_last && (i == s.len() - 1));
    end
  endtask

  // Drop valid and hold until every predicted token has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random message builder
  // --------------------------------------------------------------------------
  function automatic void put_crlf();
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endfunction

  function automatic void put_decimal(input logic [63:0] v);
    byte_t digits [$];
    do begin
      digits.push_front(byte_t'(64'(CH_ZERO) + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) frame_q.push_back(digits[i]);
  endfunction

  // small, full-width, negative-looking or junk digits
  function automatic void put_number();
    byte_t b;
    case ($urandom_range(0, 3))
      0: put_decimal(64'($urandom_range(0, 99)));
      1: put_decimal({$urandom, $urandom});
      2: begin
        frame_q.push_back(CH_ERR);
        put_decimal(64'($urandom_range(0, 999)));
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          b = $urandom;
          if (b == CH_CR) b = CH_ZERO;
          frame_q.push_back(b);
        end
      end
    endcase
  endfunction

  function automatic void put_element(input int lvl);
    int    n;
    int    sel;
    byte_t b;
    // stop opening arrays a couple of levels past the stack limit
    sel = (lvl >= 10) ? $urandom_range(0, 6) : $urandom_range(0, 9);
    case (sel)
      0, 1, 2: begin
        frame_q.push_back((sel == 2) ? CH_ERR : CH_STR);
        repeat ($urandom_range(0, 6)) begin
          b = $urandom;
          if (b == CH_CR) b = CH_LF;
          frame_q.push_back(b);
        end
        put_crlf();
      end
      3, 4: begin
        frame_q.push_back(CH_INT);
        put_number();
        put_crlf();
      end
      5, 6: begin
        frame_q.push_back(CH_BULK);
        n = $urandom_range(0, 8);
        put_decimal(64'(n));
        put_crlf();
        repeat (n) frame_q.push_back(byte_t'($urandom));
        put_crlf();
      end
      default: begin
        frame_q.push_back(CH_ARR);
        if ($urandom_range(0, 24) == 0) begin
          // count too wide for the stack entries
          put_decimal({$urandom | 32'd1, $urandom});
          put_crlf();
        end else begin
          n = $urandom_range(0, 3);
          put_decimal(64'(n));
          put_crlf();
          repeat (n) put_element(lvl + 1);
        end
      end
    endcase
  endfunction

  // One message, sometimes wrapped in a deep chain of one-element arrays,
  // sometimes with a byte inserted, overwritten or the tail cut off.
  function automatic void put_message();
    int start;
    int pos;
    start = frame_q.size();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(6, 9)) begin
        frame_q.push_back(CH_ARR);
        frame_q.push_back(CH_ZERO + 8'd1);
        put_crlf();
      end
    end
    put_element(0);
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(start, frame_q.size() - 1);
      case ($urandom_range(0, 2))
        0: frame_q.insert(pos, byte_t'($urandom));
        1: while (frame_q.size() > pos) void'(frame_q.pop_back());
        default: frame_q[pos] = byte_t'($urandom);
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_lines();
    send_text("+OK^~", 1'b1);
    send_text("-ERR bad^~", 1'b1);
    send_text("+^~", 1'b1);
    send_text("+ab^Z", 1'b1);     // LF position not checked
  endtask

  task automatic test_integers();
    send_text(":0^~", 1'b1);
    send_text(":18446744073709551615^~", 1'b1);
    send_text(":99999999999999999999^~", 1'b1);  // wraps
    send_text(":-7^~", 1'b1);
    send_text(":1a^~", 1'b1);     // non-digit still accumulates
  endtask

  task automatic test_bulk();
    send_text("$3^~a^b^~", 1'b1);  // CR inside payload is data
    send_text("$0^~^~", 1'b1);
    send_text("$2^~abX", 1'b0);    // missing trailer CR
    send_text("$2^~ab^X", 1'b0);   // missing trailer LF
    send_text("$-1^~xyz", 1'b1);   // huge length, cut by buffer end
  endtask

  task automatic test_arrays();
    send_text("*2^~:1^~+a^~", 1'b1);
    send_text("*0^~", 1'b1);
    send_text("*2^~*0^~$1^~q^~", 1'b1);
    // ninth nested level trips the depth limit
    send_text("*1^~*1^~*1^~*1^~*1^~*1^~*1^~*1^~*1^~", 1'b0);
    send_text(":5^~", 1'b1);
    send_text("*4294967296^~", 1'b0);  // count limit
    send_text("*4294967295^~", 1'b1);  // header replaced by buffer-end fault
  endtask

  task automatic test_faults();
    send_byte(8'hFF, 1'b0);
    send_text("x", 1'b0);
    send_text("!", 1'b1);          // bad type keeps its own status
    send_text("+ab", 1'b1);        // buffer end replaces a payload beat
    send_text("*2^~:1^~", 1'b1);   // array still waiting at buffer end
    send_text("$", 1'b1);
  endtask

  // Long receiver hold while the sender streams with no gaps, so the block
  // fills and stalls its input.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    wait_drained();
    rx_hold = 80;
    send_byte(CH_STR, 1'b0);
    repeat (40) send_byte(byte_t'($urandom_range(32, 126)), 1'b0);
    send_text("^~", 1'b1);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_stream();
    int   sent;
    logic end_last;
    sent = 0;
    while (sent < 570) begin
      // redraw idling per batch so some stretches run back to back
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      frame_q.delete();
      repeat ($urandom_range(1, 3)) put_message();
      end_last = $urandom_range(0, 1);
      foreach (frame_q[i]) send_byte(frame_q[i], end_last && (i == frame_q.size() - 1));
      sent += frame_q.size();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_lines();
    test_integers();
    test_bulk();
    test_arrays();
    test_faults();
    test_backpressure();
    test_random_stream();
    wait_drained();
    // let any stray beat surface
    repeat (20) @(posedge clk);
    if (token_q.size() != 0) begin
      err_count += token_q.size();
      $display("%0d predicted tokens never came out", token_q.size());
    end
    if (err_count == 0) begin
      $display("PASS resp_stream_parser");
    end else begin
      $display("FAIL resp_stream_parser");
    end
    $finish;
  end

endmodule
